[rtl/pwdb_pkg.sv]
// ----------------------------------------------------------------------------
// pwdb_pkg
// Shared types and constants for the propwash detect and D-boost block.
// ----------------------------------------------------------------------------
package pwdb_pkg;

  // Stream word layout
  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 48;

  // Configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 29;

  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
  localparam cfg_index_t CFG_SENSITIVITY  = 2'd0;
  localparam cfg_index_t CFG_D_BOOST      = 2'd1;
  localparam cfg_index_t CFG_ONE_G_RECIP  = 2'd2;
  localparam cfg_index_t CFG_FILTER_GAIN  = 2'd3;

  // Register reset values
  localparam logic [7:0]  SENSITIVITY_RST = 8'd30;
  localparam logic [7:0]  D_BOOST_RST     = 8'd0;
  localparam logic [28:0] ONE_G_RECIP_RST = 29'd131072;
  localparam logic [16:0] FILTER_GAIN_RST = 17'd256;
  localparam logic [16:0] FILTER_GAIN_MAX = 17'd65536;

  // Shared multiplier operand selection
  typedef logic [2:0] mul_sel_t;
  localparam mul_sel_t MUL_NONE = 3'd0;
  localparam mul_sel_t MUL_LP   = 3'd1;
  localparam mul_sel_t MUL_SQX  = 3'd2;
  localparam mul_sel_t MUL_SQY  = 3'd3;
  localparam mul_sel_t MUL_SQZ  = 3'd4;
  localparam mul_sel_t MUL_G    = 3'd5;
  localparam mul_sel_t MUL_GAIN = 3'd6;
  localparam mul_sel_t MUL_DIV  = 3'd7;

  localparam int MUL_W  = 30;
  localparam int PROD_W = 2 * MUL_W;

  // Square root unit
  localparam int RAD_W        = 48;
  localparam int ROOT_W       = RAD_W / 2;
  localparam int SQRT_STEPS   = ROOT_W;
  localparam int SQRT_CNT_W   = $clog2(SQRT_STEPS);

  // Detection limits, g in Q12 scaled by ten
  localparam logic [19:0] G_IN_X10    = 20'd20480;
  localparam logic [19:0] G_OUT_X10   = 20'd36864;
  localparam logic [11:0] ROLL_LIMIT  = 12'd900;
  localparam logic [10:0] PITCH_LIMIT = 11'd650;

  // Gain: 4096 + round(d * (36864 - 10 g) / 900)
  localparam logic [13:0] GAIN_ONE     = 14'd4096;
  localparam logic [24:0] GAIN_ROUND   = 25'd450;
  // ceil(2^34 / 900), exact floor division for numerators below 2^25
  localparam logic [29:0] DIV900_RECIP = 30'd19088744;
  localparam int          DIV900_SHIFT = 34;

  typedef struct packed {
    logic     load_in;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     lp_upd;
    logic     sum_load;
    logic     sum_acc;
    logic     sqrt_start;
    logic     g_upd;
    logic     flag_upd;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic sqrt_done;
  } status_t;

endpackage

[rtl/pwdb_isqrt.sv]
// ----------------------------------------------------------------------------
// pwdb_isqrt
// Bit-serial integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module pwdb_isqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [pwdb_pkg::RAD_W-1:0]  radicand,
  output logic                        done,
  output logic [pwdb_pkg::ROOT_W-1:0] root
);

  localparam int REM_W = pwdb_pkg::ROOT_W + 2;
  localparam int SH_W  = REM_W + 2;

  logic                              busy;
  logic [pwdb_pkg::SQRT_CNT_W-1:0]   cnt;
  logic [pwdb_pkg::RAD_W-1:0]        rad;
  logic [REM_W-1:0]                  rem;
  logic [SH_W-1:0]                   rem_sh;
  logic [SH_W-1:0]                   trial;
  logic                              fits;

  assign rem_sh = {rem, rad[pwdb_pkg::RAD_W-1 -: 2]};
  assign trial  = {2'b00, root, 2'b01};
  assign fits   = (rem_sh >= trial);
  assign done   = busy && (cnt == pwdb_pkg::SQRT_CNT_W'(pwdb_pkg::SQRT_STEPS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (done) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad  <= {rad[pwdb_pkg::RAD_W-3:0], 2'b00};
      rem  <= fits ? REM_W'(rem_sh - trial) : rem_sh[REM_W-1:0];
      root <= {root[pwdb_pkg::ROOT_W-2:0], fits};
    end
  end

endmodule

[rtl/pwdb_ctrl.sv]
// ----------------------------------------------------------------------------
// pwdb_ctrl
// Sequencer: walks one word through low-pass, magnitude, flags and gain.
// ----------------------------------------------------------------------------
module pwdb_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  pwdb_pkg::status_t status,
  output pwdb_pkg::cmd_t    cmd
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_LP    = 4'd1;
  localparam logic [3:0] ST_SQX   = 4'd2;
  localparam logic [3:0] ST_SQY   = 4'd3;
  localparam logic [3:0] ST_SQZ   = 4'd4;
  localparam logic [3:0] ST_SUMZ  = 4'd5;
  localparam logic [3:0] ST_ROOT  = 4'd6;
  localparam logic [3:0] ST_GMUL  = 4'd7;
  localparam logic [3:0] ST_GSAT  = 4'd8;
  localparam logic [3:0] ST_FLAGS = 4'd9;
  localparam logic [3:0] ST_DIV   = 4'd10;
  localparam logic [3:0] ST_DONE  = 4'd11;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       in_take;
  logic       out_free;

  assign in_ready = (state == ST_IDLE);
  assign in_take  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.mul_sel = pwdb_pkg::MUL_NONE;
    unique case (state)
      ST_IDLE: begin
        if (in_take) begin
          cmd.load_in = 1'b1;
          state_next  = ST_LP;
        end
      end
      ST_LP: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = pwdb_pkg::MUL_LP;
        state_next  = ST_SQX;
      end
      ST_SQX: begin
        cmd.lp_upd  = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = pwdb_pkg::MUL_SQX;
        state_next  = ST_SQY;
      end
      ST_SQY: begin
        cmd.sum_load = 1'b1;
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = pwdb_pkg::MUL_SQY;
        state_next   = ST_SQZ;
      end
      ST_SQZ: begin
        cmd.sum_acc = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = pwdb_pkg::MUL_SQZ;
        state_next  = ST_SUMZ;
      end
      ST_SUMZ: begin
        cmd.sqrt_start = 1'b1;
        state_next     = ST_ROOT;
      end
      ST_ROOT: begin
        if (status.sqrt_done) begin
          state_next = ST_GMUL;
        end
      end
      ST_GMUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = pwdb_pkg::MUL_G;
        state_next  = ST_GSAT;
      end
      ST_GSAT: begin
        cmd.g_upd  = 1'b1;
        state_next = ST_FLAGS;
      end
      ST_FLAGS: begin
        cmd.flag_upd = 1'b1;
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = pwdb_pkg::MUL_GAIN;
        state_next   = ST_DIV;
      end
      ST_DIV: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = pwdb_pkg::MUL_DIV;
        state_next  = ST_DONE;
      end
      ST_DONE: begin
        // hold until the output register is free
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_take |=> !in_ready)
    else $error("second word accepted while one is in flight");

  a_root_then_scale: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROOT) && status.sqrt_done |=> (state == ST_GMUL))
    else $error("square root finished but scaling did not follow");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_DONE))
    else $error("result word raised outside the final step");

  a_done_waits: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) && out_valid && !out_ready |=> (state == ST_DONE))
    else $error("result overwritten while the previous word stalls");

endmodule

[rtl/pwdb_dpath.sv]
// ----------------------------------------------------------------------------
// pwdb_dpath
// Datapath: config registers, state, shared multiplier, square root, flags.
// ----------------------------------------------------------------------------
module pwdb_dpath #(
  parameter int ACC_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  pwdb_pkg::cmd_t                      cmd,
  output pwdb_pkg::status_t                   status,
  input  logic                                cfg_we,
  input  pwdb_pkg::cfg_index_t                cfg_index,
  input  logic [pwdb_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [pwdb_pkg::IN_DATA_W-1:0]      in_data,
  output logic [pwdb_pkg::OUT_DATA_W-1:0]     out_data
);

  localparam int MW = pwdb_pkg::MUL_W;
  localparam int PW = pwdb_pkg::PROD_W;

  // configuration
  logic [7:0]  sensitivity;
  logic [7:0]  d_boost_percent;
  logic [28:0] one_g_reciprocal;
  logic [16:0] filter_gain;

  // held input word
  logic signed [15:0] ax;
  logic signed [15:0] ay;
  logic signed [15:0] az;
  logic signed [11:0] roll;
  logic signed [10:0] pitch;
  logic [9:0]         thr;

  // state
  logic [26:0] lp;
  logic        propwash;
  logic        boost;

  // working registers
  logic signed [PW-1:0]          prod;
  logic [31:0]                   sum_sq;
  logic [15:0]                   g;
  logic [pwdb_pkg::ROOT_W-1:0]   root;

  logic signed [MW-1:0] mul_a;
  logic signed [MW-1:0] mul_b;
  logic [16:0]          k;
  logic signed [27:0]   hp;
  logic signed [44:0]   lp_rnd;
  logic signed [28:0]   lp_sum;
  logic signed [28:0]   hp_rnd;
  logic signed [31:0]   hp_x10;
  logic signed [31:0]   sens_q16;
  logic [31:0]          sum_total;
  logic [53:0]          g_rnd;
  logic [29:0]          g_q;
  logic                 g_gate;
  logic [19:0]          g_x10;
  logic [16:0]          g_gap;
  logic [24:0]          gain_num;
  logic [13:0]          gain;
  logic [11:0]          roll_abs;
  logic [10:0]          pitch_abs;
  logic                 pw_next;
  logic                 boost_next;

  // ---- configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      sensitivity      <= pwdb_pkg::SENSITIVITY_RST;
      d_boost_percent  <= pwdb_pkg::D_BOOST_RST;
      one_g_reciprocal <= pwdb_pkg::ONE_G_RECIP_RST;
      filter_gain      <= pwdb_pkg::FILTER_GAIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pwdb_pkg::CFG_SENSITIVITY: sensitivity      <= cfg_data[7:0];
        pwdb_pkg::CFG_D_BOOST:     d_boost_percent  <= cfg_data[7:0];
        pwdb_pkg::CFG_ONE_G_RECIP: one_g_reciprocal <= cfg_data[28:0];
        pwdb_pkg::CFG_FILTER_GAIN: filter_gain      <= cfg_data[16:0];
      endcase
    end
  end

  // ---- input capture; only the low ACC_WIDTH bits of each axis count
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      ax    <= 16'($signed(in_data[ACC_WIDTH-1:0]));
      ay    <= 16'($signed(in_data[16 +: ACC_WIDTH]));
      az    <= 16'($signed(in_data[32 +: ACC_WIDTH]));
      roll  <= $signed(in_data[59:48]);
      pitch <= $signed(in_data[70:60]);
      thr   <= in_data[80:71];
    end
  end

  // ---- throttle filter
  assign k  = (filter_gain > pwdb_pkg::FILTER_GAIN_MAX) ? pwdb_pkg::FILTER_GAIN_MAX
                                                         : filter_gain;
  // before the update this is the filter error, after it the high-pass
  assign hp = $signed({2'b00, thr, 16'h0000}) - $signed({1'b0, lp});

  assign lp_rnd = $signed(prod[44:0]) + 45'sd32768;
  assign lp_sum = $signed({2'b00, lp}) + $signed(lp_rnd[44:16]);

  assign hp_rnd   = 29'(hp) + 29'sd32768;
  assign hp_x10   = (32'(hp) <<< 3) + (32'(hp) <<< 1);
  assign sens_q16 = $signed({8'h00, sensitivity, 16'h0000});

  // ---- shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.mul_sel)
      pwdb_pkg::MUL_LP: begin
        mul_a = $signed(MW'(k));
        mul_b = MW'(hp);
      end
      pwdb_pkg::MUL_SQX: begin
        mul_a = MW'(ax);
        mul_b = MW'(ax);
      end
      pwdb_pkg::MUL_SQY: begin
        mul_a = MW'(ay);
        mul_b = MW'(ay);
      end
      pwdb_pkg::MUL_SQZ: begin
        mul_a = MW'(az);
        mul_b = MW'(az);
      end
      pwdb_pkg::MUL_G: begin
        mul_a = $signed(MW'(root));
        mul_b = $signed(MW'(one_g_reciprocal));
      end
      pwdb_pkg::MUL_GAIN: begin
        mul_a = $signed(MW'(d_boost_percent));
        mul_b = $signed(MW'(g_gap));
      end
      pwdb_pkg::MUL_DIV: begin
        mul_a = $signed(MW'(gain_num));
        mul_b = $signed(pwdb_pkg::DIV900_RECIP);
      end
      pwdb_pkg::MUL_NONE: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= mul_a * mul_b;
    end
  end

  // ---- sum of squares
  assign sum_total = sum_sq + prod[31:0];

  always_ff @(posedge clk) begin
    if (cmd.sum_load) begin
      sum_sq <= prod[31:0];
    end else if (cmd.sum_acc) begin
      sum_sq <= sum_total;
    end
  end

  pwdb_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.sqrt_start),
    .radicand ({sum_total, 16'h0000}),
    .done     (status.sqrt_done),
    .root     (root)
  );

  // ---- g scaling and saturation
  assign g_rnd  = prod[53:0] + 54'h80_0000;
  assign g_q    = g_rnd[53:24];
  assign g_gate = (az > 16'sd0) && (one_g_reciprocal != '0);

  always_ff @(posedge clk) begin
    if (cmd.g_upd) begin
      if (!g_gate) begin
        g <= '0;
      end else if (g_q[29:16] != '0) begin
        g <= 16'hFFFF;
      end else begin
        g <= g_q[15:0];
      end
    end
  end

  assign g_x10 = (20'(g) << 3) + (20'(g) << 1);
  assign g_gap = (g_x10 < pwdb_pkg::G_OUT_X10) ? 17'(pwdb_pkg::G_OUT_X10 - g_x10) : '0;

  // ---- gain: divide by 900 through the reciprocal
  assign gain_num = 25'(prod[23:0]) + pwdb_pkg::GAIN_ROUND;
  assign gain     = pwdb_pkg::GAIN_ONE + prod[pwdb_pkg::DIV900_SHIFT +: 14];

  // ---- hysteresis flags
  assign roll_abs  = roll[11]  ? 12'(-roll)  : 12'(roll);
  assign pitch_abs = pitch[10] ? 11'(-pitch) : 11'(pitch);

  always_comb begin
    pw_next = propwash;
    priority if (!propwash && (g_x10 < pwdb_pkg::G_IN_X10) &&
                 (roll_abs < pwdb_pkg::ROLL_LIMIT) && (pitch_abs < pwdb_pkg::PITCH_LIMIT)) begin
      pw_next = 1'b1;
    end else if ((g_x10 > pwdb_pkg::G_OUT_X10) || (roll_abs > pwdb_pkg::ROLL_LIMIT)) begin
      pw_next = 1'b0;
    end else begin
      pw_next = propwash;
    end

    boost_next = boost;
    priority if (pw_next && !boost && (32'(hp) > sens_q16)) begin
      boost_next = 1'b1;
    end else if (hp_x10 < sens_q16) begin
      boost_next = 1'b0;
    end else begin
      boost_next = boost;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lp       <= '0;
      propwash <= 1'b0;
      boost    <= 1'b0;
    end else begin
      if (cmd.lp_upd) begin
        lp <= lp_sum[26:0];
      end
      if (cmd.flag_upd) begin
        propwash <= pw_next;
        boost    <= boost_next;
      end
    end
  end

  // ---- output word
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data <= {5'b00000, g, hp_rnd[26:16], gain, boost, propwash};
    end
  end

endmodule

[rtl/propwash_detect_and_boost.sv]
// ----------------------------------------------------------------------------
// propwash_detect_and_boost
// Propwash zone detection and derivative gain boost, one result per tick.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one control-loop tick: three accelerometer axes, roll,
//   pitch and throttle. m_axis returns one word per tick with the propwash
//   flag, the boost flag, the D gain (Q2.12), the throttle high-pass and
//   the g magnitude (Q4.12). The cfg channel writes the four registers
//   (sensitivity, d_boost_percent, one_g_reciprocal, filter_gain) by index;
//   the user must write them only while no tick is in flight, which the
//   block itself does not enforce; cfg_ready is always high.
//   A new tick is taken only once the previous one has finished. The
//   24-step bit-serial square root of the magnitude takes most of the time;
//   the rest is a handful of passes through one shared 30x30 multiplier.
//   The result sits in an output register, so the next tick is accepted
//   while a result still waits; if the receiver stalls, the block holds its
//   finished word in the final step until the register frees up.
//   Reset clears the throttle low-pass, both flags and the output valid,
//   and returns the registers to their defaults.
// ----------------------------------------------------------------------------
module propwash_detect_and_boost #(
  parameter int ACC_WIDTH = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // acc_x[15:0], acc_y[31:16], acc_z[47:32], roll_angle[59:48],
  // pitch_angle[70:60], throttle[80:71], zero fill above
  input  logic [pwdb_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // in_propwash[0], boost_active[1], boost_gain[15:2],
  // throttle_highpass[26:16], g_force[42:27], zero fill above
  output logic [pwdb_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [pwdb_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [pwdb_pkg::CFG_DATA_W-1:0]    cfg_data
);

  pwdb_pkg::cmd_t    cmd;
  pwdb_pkg::status_t status;

  assign cfg_ready = 1'b1;

  pwdb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .status    (status),
    .cmd       (cmd)
  );

  pwdb_dpath #(
    .ACC_WIDTH (ACC_WIDTH)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (s_axis_tdata),
    .out_data  (m_axis_tdata)
  );

endmodule

[test/tb_propwash_detect_and_boost.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_propwash_detect_and_boost
// Self-checking regression for the propwash detect and D-boost block.
// ----------------------------------------------------------------------------
// Ticks go in on s_axis and are predicted in the testbench: throttle low-pass
// and high-pass, g magnitude through an integer square root, the propwash and
// boost hysteresis and the D gain. Every result word on m_axis is checked
// against the oldest prediction. A directed set covers field extremes, the
// flag thresholds and the register corner values; random phases then run
// flight-like ticks under random register settings, with sender bursts and
// gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_propwash_detect_and_boost;

  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_TICKS   = 150;
  localparam int DRAIN_CYCLES  = 40;

  // One input word, last field in the lowest bits
  typedef struct packed {
    logic [9:0]         thr;
    logic signed [10:0] pitch;
    logic signed [11:0] roll;
    logic signed [15:0] az;
    logic signed [15:0] ay;
    logic signed [15:0] ax;
  } tick_t;

  // One result word, last field in the lowest bits
  typedef struct packed {
    logic [15:0]        g_force;
    logic signed [10:0] highpass;
    logic [13:0]        gain;
    logic               boost;
    logic               propwash;
  } result_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [pwdb_pkg::IN_DATA_W-1:0]   s_axis_tdata = '0;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  logic [pwdb_pkg::OUT_DATA_W-1:0]  m_axis_tdata;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  pwdb_pkg::cfg_index_t             cfg_index = pwdb_pkg::CFG_SENSITIVITY;
  logic [pwdb_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

  // Predicted block state and registers
  longint      lp_state;
  logic        pw_state;
  logic        boost_state;
  logic [7:0]  sens_reg;
  logic [7:0]  dboost_reg;
  logic [28:0] recip_reg;
  logic [16:0] kgain_reg;

  result_t awaited_results[$];
  int      bad_results = 0;

  int burst_left = 0;
  int burst_max = 1;
  int gap_max = 0;
  int rx_stall_max = 0;
  int rx_run = 0;
  int thr_walk = 0;

  propwash_detect_and_boost dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Advance the predicted state by one tick and return its result word.
  function automatic result_t compute_tick_result(input tick_t t);
    longint ax, ay, az, roll, pitch, thr, k, thr_q16, hp, hp_r, g, gain;
    longint aroll, apitch, sens_q16, g_out_x10;
    longint unsigned s, v, root, bitv, q;
    result_t r;
    ax = t.ax;
    ay = t.ay;
    az = t.az;
    roll = t.roll;
    pitch = t.pitch;
    thr = t.thr;
    g_out_x10 = longint'(pwdb_pkg::G_OUT_X10);
    k = (kgain_reg > pwdb_pkg::FILTER_GAIN_MAX) ? longint'(pwdb_pkg::FILTER_GAIN_MAX)
                                                : longint'(kgain_reg);
    thr_q16 = thr * 65536;

    lp_state = lp_state + ((k * (thr_q16 - lp_state) + 32768) >>> 16);
    hp = thr_q16 - lp_state;
    hp_r = (hp + 32768) >>> 16;

    if (az > 0 && recip_reg != 0) begin
      s = ax * ax + ay * ay + az * az;
      v = s << 16;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (v >= root + bitv) begin
          v = v - (root + bitv);
          root = (root >> 1) + bitv;
        end else begin
          root = root >> 1;
        end
        bitv = bitv >> 2;
      end
      q = (root * recip_reg + (64'd1 << 23)) >> 24;
      g = (q > 65535) ? 65535 : longint'(q);
    end else begin
      g = 0;
    end

    aroll = (roll < 0) ? -roll : roll;
    apitch = (pitch < 0) ? -pitch : pitch;
    if (!pw_state && g * 10 < longint'(pwdb_pkg::G_IN_X10) &&
        aroll < longint'(pwdb_pkg::ROLL_LIMIT) &&
        apitch < longint'(pwdb_pkg::PITCH_LIMIT)) begin
      pw_state = 1'b1;
    end else if (g * 10 > g_out_x10 || aroll > longint'(pwdb_pkg::ROLL_LIMIT)) begin
      pw_state = 1'b0;
    end

    sens_q16 = longint'(sens_reg) * 65536;
    if (pw_state && !boost_state && hp > sens_q16) begin
      boost_state = 1'b1;
    end else if (hp * 10 < sens_q16) begin
      boost_state = 1'b0;
    end

    gain = longint'(pwdb_pkg::GAIN_ONE);
    if (g * 10 < g_out_x10) begin
      gain = gain + (longint'(dboost_reg) * (g_out_x10 - g * 10) + 450) / 900;
    end

    r.propwash = pw_state;
    r.boost = boost_state;
    r.gain = gain[13:0];
    r.highpass = hp_r[10:0];
    r.g_force = g[15:0];
    return r;
  endfunction

  // Check result words, track register writes, predict accepted ticks.
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst) begin
      lp_state = 0;
      pw_state = 1'b0;
      boost_state = 1'b0;
      sens_reg = pwdb_pkg::SENSITIVITY_RST;
      dboost_reg = pwdb_pkg::D_BOOST_RST;
      recip_reg = pwdb_pkg::ONE_G_RECIP_RST;
      kgain_reg = pwdb_pkg::FILTER_GAIN_RST;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[$bits(result_t)-1:0];
        if (awaited_results.size() == 0) begin
          bad_results++;
          if (bad_results <= 10)
            $display("%0t: result word with no tick pending: pw=%0d boost=%0d gain=%0d hp=%0d g=%0d",
                     $realtime, got.propwash, got.boost, got.gain, got.highpass, got.g_force);
        end else begin
          want = awaited_results.pop_front();
          if (got !== want) begin
            bad_results++;
            if (bad_results <= 10) begin
              $display("%0t: result mismatch", $realtime);
              $display("  expected pw=%0d boost=%0d gain=%0d hp=%0d g=%0d",
                       want.propwash, want.boost, want.gain, want.highpass, want.g_force);
              $display("  actual   pw=%0d boost=%0d gain=%0d hp=%0d g=%0d",
                       got.propwash, got.boost, got.gain, got.highpass, got.g_force);
            end
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          pwdb_pkg::CFG_SENSITIVITY: sens_reg = cfg_data[7:0];
          pwdb_pkg::CFG_D_BOOST:     dboost_reg = cfg_data[7:0];
          pwdb_pkg::CFG_ONE_G_RECIP: recip_reg = cfg_data[28:0];
          pwdb_pkg::CFG_FILTER_GAIN: kgain_reg = cfg_data[16:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        awaited_results.push_back(compute_tick_result(s_axis_tdata[$bits(tick_t)-1:0]));
    end
  end

  // Receiver: alternate ready stretches and stall stretches.
  always @(posedge clk) begin
    if (rx_run == 0) begin
      if (m_axis_tready && rx_stall_max > 0) begin
        m_axis_tready <= 1'b0;
        rx_run = $urandom_range(rx_stall_max, 1);
      end else begin
        m_axis_tready <= 1'b1;
        rx_run = $urandom_range(12, 1);
      end
    end else begin
      rx_run--;
    end
  end

  function automatic tick_t mk(input int ax, input int ay, input int az,
                               input int roll, input int pitch, input int thr);
    tick_t t;
    t.ax = ax[15:0];
    t.ay = ay[15:0];
    t.az = az[15:0];
    t.roll = roll[11:0];
    t.pitch = pitch[10:0];
    t.thr = thr[9:0];
    return t;
  endfunction

  // Flight-like tick: acceleration around the current one-g count, attitude
  // mostly inside the limits, throttle as a random walk with jumps.
  function automatic tick_t flight_tick();
    tick_t t;
    logic [95:0] raw;
    int cnt, lo, hi, m, a3, roll, pitch, az, sel;
    if ($urandom_range(9, 0) < 2) begin
      raw = {$urandom, $urandom, $urandom};
      t = raw[$bits(tick_t)-1:0];
      return t;
    end
    cnt = (recip_reg == 0) ? 2048 : 268435456 / int'(recip_reg);
    if (cnt < 1) cnt = 1;
    if (cnt > 16000) cnt = 16000;
    case ($urandom_range(3, 0))
      0: begin lo = 0; hi = cnt / 2 + 1; end
      1: begin lo = cnt * 2 / 5; hi = cnt + 1; end
      2: begin lo = cnt; hi = 2 * cnt + 1; end
      default: begin lo = 0; hi = 32767; end
    endcase
    if (hi > 32767) hi = 32767;
    m = $urandom_range(hi, lo);
    a3 = m / 3;
    az = ($urandom_range(9, 0) == 0) ? -int'($urandom_range(m, 0))
                                      : int'($urandom_range((m > 0) ? m : 1, 1));
    sel = $urandom_range(19, 0);
    if (sel == 0) roll = $urandom;
    else if (sel == 1) roll = ($urandom_range(1, 0) ? 900 : 901) * ($urandom_range(1, 0) ? 1 : -1);
    else roll = int'($urandom_range(1700, 0)) - 850;
    sel = $urandom_range(19, 0);
    if (sel == 0) pitch = $urandom;
    else if (sel == 1) pitch = ($urandom_range(1, 0) ? 650 : 649) * ($urandom_range(1, 0) ? 1 : -1);
    else pitch = int'($urandom_range(1400, 0)) - 700;
    sel = $urandom_range(9, 0);
    if (sel < 7) thr_walk = thr_walk + int'($urandom_range(120, 0)) - 60;
    else if (sel < 9) thr_walk = $urandom_range(1000, 0);
    else thr_walk = $urandom_range(1023, 0);
    if (thr_walk < 0) thr_walk = 0;
    if (thr_walk > 1023) thr_walk = 1023;
    return mk(int'($urandom_range(2 * a3, 0)) - a3, int'($urandom_range(2 * a3, 0)) - a3,
              az, roll, pitch, thr_walk);
  endfunction

  // Send one tick; bursts of random length with random gaps between them.
  task automatic send_tick(input tick_t t);
    int gap;
    if (burst_left == 0) begin
      gap = (gap_max == 0) ? 0 : $urandom_range(gap_max, 0);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(burst_max, 1);
    end
    s_axis_tdata <= {{(pwdb_pkg::IN_DATA_W - $bits(tick_t)){1'b0}}, t};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    burst_left--;
  endtask

  // Hold the sender until every predicted word has come back.
  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(input pwdb_pkg::cfg_index_t idx,
                           input logic [pwdb_pkg::CFG_DATA_W-1:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Reset registers: field extremes, flag thresholds, saturation.
  task automatic test_directed_ticks();
    gap_max = 40;
    burst_max = 3;
    rx_stall_max = 20;
    send_tick(mk(0, 0, 2048, 0, 0, 0));
    send_tick(mk(32767, -32768, 32767, 2047, 1023, 1023));
    send_tick(mk(-32768, 32767, -32768, -2048, -1024, 0));
    // Z at zero: g drops to zero, propwash and then boost enter
    send_tick(mk(100, -100, 0, 0, 0, 500));
    send_tick(mk(0, 0, 1, 899, 649, 1000));
    // roll exactly at the limit holds the flag
    send_tick(mk(0, 0, 1, 900, -650, 1000));
    send_tick(mk(0, 0, 1, -901, 0, 1000));
    // re-enter with throttle cut: boost leaves on negative high-pass
    send_tick(mk(0, 0, 1023, 0, 0, 0));
    send_tick(mk(0, 0, 1843, 0, 0, 300));
    send_tick(mk(0, 0, 1844, 0, 0, 300));
    // exactly half a g: no entry
    send_tick(mk(0, 0, 1024, 0, -649, 300));
    send_tick(mk(0, 0, 1023, 0, 649, 300));
    send_tick(mk(-32768, -32768, 32767, 0, 0, 0));
    send_tick(mk(1, 0, -1, 0, 0, 1));
    wait_for_results();
  endtask

  task automatic test_register_extremes();
    gap_max = 0;
    burst_max = 1;
    rx_stall_max = 0;
    write_reg(pwdb_pkg::CFG_ONE_G_RECIP, '0);
    send_tick(mk(0, 0, 2048, 0, 0, 800));
    wait_for_results();
    // gain above one acts as one
    write_reg(pwdb_pkg::CFG_FILTER_GAIN, 29'd131071);
    send_tick(mk(0, 0, 2048, 0, 0, 1000));
    send_tick(mk(0, 0, 2048, 0, 0, 0));
    wait_for_results();
    write_reg(pwdb_pkg::CFG_FILTER_GAIN, '0);
    write_reg(pwdb_pkg::CFG_SENSITIVITY, '0);
    write_reg(pwdb_pkg::CFG_D_BOOST, 29'd255);
    write_reg(pwdb_pkg::CFG_ONE_G_RECIP, 29'd268435456);
    send_tick(mk(0, 0, 1, 0, 0, 700));
    send_tick(mk(0, 0, 0, 0, 0, 0));
    wait_for_results();
    write_reg(pwdb_pkg::CFG_FILTER_GAIN, 29'd65536);
    write_reg(pwdb_pkg::CFG_SENSITIVITY, 29'd255);
    write_reg(pwdb_pkg::CFG_ONE_G_RECIP, 29'd1);
    send_tick(mk(32767, 32767, 32767, 0, 0, 1023));
    send_tick(mk(0, 0, 5, 0, 0, 0));
    wait_for_results();
  endtask

  task automatic test_random_flight();
    logic [pwdb_pkg::CFG_DATA_W-1:0] junk;
    logic [7:0] sens;
    logic [28:0] recip;
    logic [16:0] kgain;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case ($urandom_range(4, 0))
        0: sens = 8'd0;
        1: sens = 8'd255;
        default: sens = 8'($urandom_range(60, 0));
      endcase
      case ($urandom_range(9, 0))
        0: recip = 29'd1;
        1: recip = 29'd268435456;
        2: recip = '0;
        default: recip = 29'(268435456 / $urandom_range(16384, 256));
      endcase
      case ($urandom_range(7, 0))
        0: kgain = '0;
        1: kgain = pwdb_pkg::FILTER_GAIN_MAX;
        2: kgain = 17'($urandom_range(131071, 65537));
        default: kgain = 17'($urandom_range(8192, 1));
      endcase
      junk = pwdb_pkg::CFG_DATA_W'($urandom);
      write_reg(pwdb_pkg::CFG_SENSITIVITY, {junk[28:8], sens});
      junk = pwdb_pkg::CFG_DATA_W'($urandom);
      write_reg(pwdb_pkg::CFG_D_BOOST, {junk[28:8], 8'($urandom_range(255, 0))});
      write_reg(pwdb_pkg::CFG_ONE_G_RECIP, recip);
      junk = pwdb_pkg::CFG_DATA_W'($urandom);
      write_reg(pwdb_pkg::CFG_FILTER_GAIN, {junk[28:17], kgain});
      gap_max = (p % 4 == 0) ? 0 : $urandom_range(70, 1);
      burst_max = $urandom_range(10, 1);
      rx_stall_max = (p % 4 == 0) ? 0 : $urandom_range(45, 1);
      for (int i = 0; i < PHASE_TICKS; i++) send_tick(flight_tick());
      wait_for_results();
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_ticks();
    test_register_extremes();
    test_random_flight();
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (bad_results == 0 && awaited_results.size() == 0) begin
      $display("propwash_detect_and_boost regression: pass");
    end else begin
      $display("propwash_detect_and_boost regression: fail");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("propwash_detect_and_boost regression: fail");
    $finish;
  end

endmodule
